// File: rtl/dpfmv_pkg.sv
// ----------------------------------------------------------------------------
// dpfmv_pkg
// Shared types and constants of the dual path frame match verifier.
// ----------------------------------------------------------------------------
package dpfmv_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam logic [15:0] WINDOW_RESET = 16'd250;

    typedef enum logic [2:0] {
        V_VERIFIED  = 3'd0,
        V_BUFFERED  = 3'd1,
        V_STALE     = 3'd2,
        V_TIMEOUT   = 3'd3,
        V_IGNORED   = 3'd4,
        V_DUPLICATE = 3'd5,
        V_FULL      = 3'd6
    } t_verdict;

    localparam logic [1:0] PATH_A    = 2'd0;
    localparam logic [1:0] PATH_LOOP = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic        loopback;
        logic        own;
        logic [63:0] hash;
        logic [31:0] now;
    } t_req;

    typedef struct packed {
        t_verdict    verdict;
        logic [63:0] hash;
        logic [1:0]  path;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SWEEP,
        S_EMIT
    } t_state;

endpackage

// File: rtl/dpfmv_front.sv
// ----------------------------------------------------------------------------
// dpfmv_front
// Accepts arrivals, classifies the path and holds a two-entry request queue.
// ----------------------------------------------------------------------------
module dpfmv_front import dpfmv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_path,
    input  logic [63:0]  i_hash,
    input  logic [31:0]  i_time,
    output logic         o_req_valid,
    input  logic         i_req_pop,
    output t_req         o_req
);
    t_req       r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       w_push;
    t_req       w_new;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rd];

    always_comb begin
        w_new.loopback = (i_path == PATH_LOOP);
        w_new.own      = (i_path != PATH_A);
        w_new.hash     = i_hash;
        w_new.now      = i_time;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_new;
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_req_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_req_pop};
        end
    end
endmodule

// File: rtl/dpfmv_back.sv
// ----------------------------------------------------------------------------
// dpfmv_back
// Table engine: serial search, decision, timeout sweep, registered output.
// ----------------------------------------------------------------------------
module dpfmv_back import dpfmv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [15:0]  i_window,
    input  logic         i_req_valid,
    output logic         o_req_pop,
    input  t_req         i_req,
    output logic         o_valid,
    input  logic         i_ready,
    output t_res         o_res
);
    logic [TABLE_ENTRIES-1:0] r_valid, n_valid;
    logic        m_path [TABLE_ENTRIES];
    logic [63:0] m_hash [TABLE_ENTRIES];
    logic [31:0] m_time [TABLE_ENTRIES];

    t_state      r_state, n_state;
    t_req        r_req, n_req;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic        r_oth_hit, n_oth_hit;
    logic        r_own_hit, n_own_hit;
    logic        r_free_hit, n_free_hit;
    logic [SLOT_W-1:0] r_oth, n_oth;
    logic [SLOT_W-1:0] r_free, n_free;
    logic        r_ovalid, n_ovalid;
    t_res        r_out, n_out;
    t_res        r_hold, n_hold;

    logic        w_we;
    logic [SLOT_W-1:0] w_wa;
    logic        rd_path;
    logic [63:0] rd_hash;
    logic [31:0] rd_time;
    logic [SLOT_W-1:0] w_ri;
    logic [31:0] w_age;
    logic        w_hmatch;
    logic        w_out_free;
    logic        w_tmo;

    assign w_ri     = r_idx;
    assign rd_path  = m_path[w_ri];
    assign rd_hash  = m_hash[w_ri];
    assign rd_time  = m_time[w_ri];
    assign w_age    = r_req.now - rd_time;
    assign w_hmatch = r_valid[w_ri] && (rd_hash == r_req.hash);
    assign w_tmo    = r_valid[w_ri] && (w_age > {16'd0, i_window});
    assign w_out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_path[w_wa] <= r_req.own;
            m_hash[w_wa] <= r_req.hash;
            m_time[w_wa] <= r_req.now;
        end
    end

    always_comb begin
        n_state = r_state; n_req = r_req; n_idx = r_idx; n_valid = r_valid;
        n_oth_hit = r_oth_hit; n_own_hit = r_own_hit; n_free_hit = r_free_hit;
        n_oth = r_oth; n_free = r_free; n_hold = r_hold;
        n_ovalid = r_ovalid && !i_ready; n_out = r_out;
        o_req_pop = 1'b0; w_we = 1'b0; w_wa = r_oth;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && w_out_free) begin
                    o_req_pop = 1'b1;
                    n_req = i_req;
                    n_idx = '0;
                    n_oth_hit = 1'b0; n_own_hit = 1'b0; n_free_hit = 1'b0;
                    if (i_req.loopback) begin
                        n_ovalid = 1'b1;
                        n_out = '{V_IGNORED, i_req.hash, PATH_LOOP, 1'b1};
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_hmatch && (rd_path != r_req.own) && !r_oth_hit) begin
                    n_oth_hit = 1'b1; n_oth = w_ri;
                end
                if (w_hmatch && (rd_path == r_req.own)) n_own_hit = 1'b1;
                if (!r_valid[w_ri] && !r_free_hit) begin
                    n_free_hit = 1'b1; n_free = w_ri;
                end
                if (r_idx == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    n_idx = r_oth_hit ? r_oth : n_oth;
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                // arrival result is held until the sweep shows whether it is last
                n_hold.last = 1'b0;
                n_hold.hash = r_req.hash;
                n_hold.path = {1'b0, r_req.own};
                if (r_oth_hit) begin
                    if (w_age <= {16'd0, i_window}) begin
                        n_valid[r_oth] = 1'b0;
                        n_hold.verdict = V_VERIFIED;
                    end else begin
                        n_hold.verdict = V_STALE;
                        n_hold.hash = rd_hash;
                        n_hold.path = {1'b0, rd_path};
                        w_we = 1'b1; w_wa = r_oth;
                    end
                end else if (r_own_hit) begin
                    n_hold.verdict = V_DUPLICATE;
                end else if (!r_free_hit) begin
                    n_hold.verdict = V_FULL;
                end else begin
                    n_hold.verdict = V_BUFFERED;
                    n_valid[r_free] = 1'b1;
                    w_we = 1'b1; w_wa = r_free;
                end
                n_idx = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (!w_tmo || w_out_free) begin
                    if (w_tmo) begin
                        // release held result, hold the new timeout
                        n_ovalid = 1'b1;
                        n_out = r_hold;
                        n_hold = '{V_TIMEOUT, rd_hash, {1'b0, rd_path}, 1'b0};
                        n_valid[w_ri] = 1'b0;
                    end
                    if (r_idx == SLOT_W'(TABLE_ENTRIES - 1)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out = r_hold;
                    n_out.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req; r_oth <= n_oth; r_free <= n_free; r_out <= n_out;
        r_hold <= n_hold;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_idx <= '0; r_ovalid <= 1'b0;
            r_oth_hit <= 1'b0; r_own_hit <= 1'b0; r_free_hit <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_idx <= n_idx;
            r_ovalid <= n_ovalid; r_oth_hit <= n_oth_hit; r_own_hit <= n_own_hit;
            r_free_hit <= n_free_hit;
        end
    end
endmodule

// File: rtl/dual_path_frame_match_verifier_top.sv
// ----------------------------------------------------------------------------
// dual_path_frame_match_verifier_top
// Matches frames arriving on two redundant paths within a time window.
// ----------------------------------------------------------------------------
// Each arrival passes through a request pop, one search pass over the 32-slot
// table, a decision, one timeout sweep at one slot per cycle while no timeout
// waits on a stalled output, and a stage for the last result, which also waits
// for the output; a loopback request is answered at its pop. A two-entry queue
// buffers arrivals.
module dual_path_frame_match_verifier_top import dpfmv_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // arrival_path
    input  logic [95:0]  s_axis_tdata,   // frame_hash[63:0], arrival_time_us[95:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,   // verdict
    output logic [71:0]  m_axis_tdata,   // result_hash[63:0], result_path[65:64]
    output logic         m_axis_tlast
);
    logic [15:0] r_window;
    logic        w_req_valid;
    logic        w_req_pop;
    t_req        w_req;
    t_res        w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_window <= WINDOW_RESET;
        else if (i_cfg_we) r_window <= i_cfg_wdata;
    end

    dpfmv_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_path(s_axis_tuser), .i_hash(s_axis_tdata[63:0]),
        .i_time(s_axis_tdata[95:64]),
        .o_req_valid(w_req_valid), .i_req_pop(w_req_pop), .o_req(w_req)
    );

    dpfmv_back u_back (
        .i_clk, .i_rst_n, .i_window(r_window),
        .i_req_valid(w_req_valid), .o_req_pop(w_req_pop), .i_req(w_req),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tuser = w_res.verdict;
    assign m_axis_tdata = {6'd0, w_res.path, w_res.hash};
    assign m_axis_tlast = w_res.last;

    a_pop_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_pop |-> w_req_valid) else $error("pop of empty queue");
    a_ignored_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_res.verdict == V_IGNORED) |-> m_axis_tlast)
        else $error("ignored result not last");
    a_ignored_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_res.verdict == V_IGNORED) |-> w_res.path == PATH_LOOP)
        else $error("ignored result path");
endmodule

// File: tb/sv/dual_path_frame_match_verifier_top_tb.sv
// ----------------------------------------------------------------------------
// dual_path_frame_match_verifier_top_tb
// Drives path A/B and loopback arrivals with matching, stale, duplicate, full-table and
// timeout cases through the verifier, predicts every verdict with a table
// model, and compares results in order. Window is changed between phases.
// ----------------------------------------------------------------------------
module dual_path_frame_match_verifier_top_tb;
    import dpfmv_pkg::*;

    typedef struct {
        t_verdict    verdict;
        logic [63:0] hash;
        logic [1:0]  path;
        logic        last;
    } t_verdict_rec;

    class match_scoreboard;
        logic [15:0]  window_us;
        bit           slot_valid [TABLE_ENTRIES];
        bit           slot_path  [TABLE_ENTRIES];
        logic [63:0]  slot_hash  [TABLE_ENTRIES];
        logic [31:0]  slot_time  [TABLE_ENTRIES];
        t_verdict_rec pending_verdicts[$];
        int           mismatches;

        function new();
            window_us = WINDOW_RESET;
            mismatches = 0;
            foreach (slot_valid[i]) slot_valid[i] = 0;
        endfunction

        function void push(t_verdict v, logic [63:0] h, logic [1:0] p);
            t_verdict_rec r;
            r.verdict = v; r.hash = h; r.path = p; r.last = 0;
            pending_verdicts.push_back(r);
        endfunction

        function int find_slot(logic [63:0] h, bit p);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot_valid[i] && slot_hash[i] == h && slot_path[i] == p) return i;
            return -1;
        endfunction

        function void note_arrival(logic [1:0] path_in, logic [63:0] h, logic [31:0] now);
            bit own;
            int s;
            logic [31:0] age;
            if (path_in == PATH_LOOP) begin
                push(V_IGNORED, h, PATH_LOOP);
            end else begin
                own = (path_in != PATH_A);
                s = find_slot(h, !own);
                if (s >= 0) begin
                    age = now - slot_time[s];
                    if (age <= window_us) begin
                        slot_valid[s] = 0;
                        push(V_VERIFIED, h, {1'b0, own});
                    end else begin
                        push(V_STALE, slot_hash[s], {1'b0, slot_path[s]});
                        slot_path[s] = own; slot_hash[s] = h; slot_time[s] = now;
                    end
                end else if (find_slot(h, own) >= 0) begin
                    push(V_DUPLICATE, h, {1'b0, own});
                end else begin
                    s = -1;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (!slot_valid[i] && s < 0) s = i;
                    if (s < 0) begin
                        push(V_FULL, h, {1'b0, own});
                    end else begin
                        slot_valid[s] = 1; slot_path[s] = own;
                        slot_hash[s] = h; slot_time[s] = now;
                        push(V_BUFFERED, h, {1'b0, own});
                    end
                end
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (slot_valid[i] && (now - slot_time[i]) > {16'd0, window_us}) begin
                        slot_valid[i] = 0;
                        push(V_TIMEOUT, slot_hash[i], {1'b0, slot_path[i]});
                    end
                end
            end
            pending_verdicts[pending_verdicts.size() - 1].last = 1;
        endfunction

        function void check_result(logic [2:0] v, logic [63:0] h, logic [1:0] p, logic l);
            t_verdict_rec e;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: verdict %0d hash %h path %0d last %0b",
                             v, h, p, l);
                return;
            end
            e = pending_verdicts.pop_front();
            if (v !== e.verdict || h !== e.hash || p !== e.path || l !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %h %0d %0b, got %0d %h %0d %0b",
                             e.verdict, e.hash, e.path, e.last, v, h, p, l);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [2:0]  m_axis_tuser;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    dual_path_frame_match_verifier_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    match_scoreboard sb;
    logic [31:0] clock_us;
    logic [63:0] recent_hashes[$];
    int          idle_cycles;
    bit          hold_off;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_wdata = 0;
        s_axis_tvalid = 0; s_axis_tuser = 0; s_axis_tdata = 0;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3)) @(posedge i_clk);
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[65:64],
                            m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_arrival(logic [1:0] path, logic [63:0] h, logic [31:0] t,
                                bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= path;
        s_axis_tdata  <= {t, h};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_arrival(path, h, t);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_window(logic [15:0] w);
        i_cfg_we <= 1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.window_us = w;
    endtask

    task automatic random_arrival();
        logic [1:0]  p;
        logic [63:0] h;
        int          r;
        r = $urandom_range(0, 99);
        p = (r < 5) ? 2'd2 : (r < 8) ? 2'd3 : 2'($urandom_range(0, 1));
        if (recent_hashes.size() > 0 && $urandom_range(0, 99) < 60)
            h = recent_hashes[$urandom_range(0, recent_hashes.size() - 1)];
        else begin
            h = {$urandom, $urandom};
            recent_hashes.push_back(h);
            if (recent_hashes.size() > 40) void'(recent_hashes.pop_front());
        end
        clock_us += $urandom_range(0, 9) == 0 ? $urandom_range(100, 600)
                                              : $urandom_range(0, 40);
        send_arrival(p, h, clock_us, 1);
    endtask

    initial begin
        sb = new();
        hold_off = 0;
        clock_us = 32'hFFFF_FF00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, loopback, match, duplicate, stale, wrap
        send_arrival(2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_arrival(2'd0, 64'h0, 32'h0, 0);
        send_arrival(2'd1, 64'h0, 32'd250, 0);
        send_arrival(2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF0, 0);
        send_arrival(2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF8, 0);
        send_arrival(2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0010, 0);
        send_arrival(2'd1, 64'hA5A5_5A5A_0F0F_F0F0, 32'd100, 0);
        send_arrival(2'd0, 64'hA5A5_5A5A_0F0F_F0F0, 32'd351, 0);
        send_arrival(2'd2, 64'h5A5A_A5A5_F0F0_0F0F, 32'h5555_AAAA, 0);
        drain();

        // zero window and table full
        write_window(16'd0);
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            send_arrival(2'd1, 64'h1000 + i, 32'd1000, 0);
        send_arrival(2'd0, 64'h1000, 32'd1000, 0);
        send_arrival(2'd0, 64'h1001, 32'd1001, 0);
        drain();

        write_window(16'hFFFF);
        clock_us = 32'hFFFF_FF00;
        for (int i = 0; i < 40; i++) begin
            if (i == 20) hold_off = 1;
            random_arrival();
        end
        drain();

        write_window(16'd100);
        for (int i = 0; i < 30; i++) random_arrival();
        drain();

        write_window(16'd250);
        for (int i = 0; i < 35; i++) random_arrival();
        drain();

        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/dpfmv_pkg.sv
rtl/dpfmv_front.sv
rtl/dpfmv_back.sv
rtl/dual_path_frame_match_verifier_top.sv
tb/sv/dual_path_frame_match_verifier_top_tb.sv
